// ----- src/ple_pkg.sv -----
// Shared types and codes for the positional list engine.
package ple_pkg;

  // Request action codes
  typedef enum logic [2:0] {
    ACT_APPEND    = 3'd0,
    ACT_INSERT    = 3'd1,
    ACT_PUSH      = 3'd2,
    ACT_REM_POS   = 3'd3,
    ACT_REM_FRONT = 3'd4,
    ACT_REM_BACK  = 3'd5
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_PUT,
    S_FETCH,
    S_TAKE,
    S_MRD,
    S_MWR,
    S_DONE
  } state_t;

  // One finished result beat
  typedef struct packed {
    status_t     status;
    logic [7:0]  removed_data;
    logic [4:0]  entry_count;
  } result_t;

endpackage

// ----- src/ple_req_if.sv -----
// Request channel: valid/ready handshake carrying one list request.
interface ple_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] item_data;
  logic [7:0] position;

  modport source (output valid, output action, output item_data, output position,
                  input ready);
  modport sink   (input valid, input action, input item_data, input position,
                  output ready);
endinterface

// ----- src/ple_rsp_if.sv -----
// Result channel: valid/ready handshake carrying one request result.
interface ple_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] removed_data;
  logic [4:0] entry_count;

  modport source (output valid, output status, output removed_data, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input removed_data, input entry_count,
                  output ready);
endinterface

// ----- src/ple_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ple_ctrl.sv -----
// Request sequencer: decodes one request and moves entries one at a time.
module ple_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic [2:0]               req_action,
  input  logic [7:0]               req_data,
  input  logic [7:0]               req_pos,
  input  logic                     slot_free,
  output logic                     res_valid,
  output ple_pkg::result_t         res,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [7:0]               ram_wdata,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [7:0]               ram_rdata
);
  import ple_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PCW = (CW > 8) ? CW : 8;

  state_t         state_r, state_nxt;
  logic [7:0]     data_r, data_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  status_t        status_r, status_nxt;
  logic [7:0]     removed_r, removed_nxt;

  logic           pos_bad;
  logic [7:0]     pos_m1;
  logic [AW-1:0]  ptr_dec;
  logic [AW-1:0]  ptr_inc;

  // Position checks against the current count
  assign pos_bad = (req_pos == 8'd0) || (PCW'(req_pos) > PCW'(count_r));
  assign pos_m1  = req_pos - 8'd1;
  assign ptr_dec = ptr_r - AW'(1);
  assign ptr_inc = ptr_r + AW'(1);

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    idx_r     <= idx_nxt;
    ptr_r     <= ptr_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
  end

  // Next state and outputs
  always_comb begin
    state_nxt   = state_r;
    data_nxt    = data_r;
    idx_nxt     = idx_r;
    ptr_nxt     = ptr_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    req_ready   = 1'b0;
    res_valid   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = ptr_r;
    ram_wdata   = ram_rdata;
    ram_raddr   = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          data_nxt    = req_data;
          status_nxt  = ST_OK;
          removed_nxt = 8'd0;
          ptr_nxt     = AW'(count_r);
          unique case (req_action)
            ACT_APPEND, ACT_INSERT, ACT_PUSH: begin
              if (count_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                // Pick the slot that takes the new byte
                if (req_action == ACT_PUSH) begin
                  idx_nxt = '0;
                end else if (req_action == ACT_INSERT && !pos_bad) begin
                  idx_nxt = AW'(pos_m1);
                end else begin
                  idx_nxt = AW'(count_r);
                end
                state_nxt = (AW'(count_r) > idx_nxt) ? S_RD : S_PUT;
              end
            end
            ACT_REM_POS, ACT_REM_FRONT, ACT_REM_BACK: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else if (req_action == ACT_REM_FRONT) begin
                idx_nxt   = '0;
                state_nxt = S_FETCH;
              end else if (req_action == ACT_REM_BACK) begin
                idx_nxt   = AW'(count_r - CW'(1));
                state_nxt = S_FETCH;
              end else if (pos_bad) begin
                status_nxt = ST_BAD_POS;
                state_nxt  = S_DONE;
              end else begin
                idx_nxt   = AW'(pos_m1);
                state_nxt = S_FETCH;
              end
            end
            default: begin
              // Unused codes: no change, plain ok result
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Insert: read the entry below the hole
      S_RD: begin
        ram_raddr = ptr_dec;
        state_nxt = S_WR;
      end

      // Insert: move it one slot back
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = ram_rdata;
        ptr_nxt   = ptr_dec;
        state_nxt = (ptr_dec > idx_r) ? S_RD : S_PUT;
      end

      // Insert: drop the new byte into the hole
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = data_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end

      // Remove: read the victim entry
      S_FETCH: begin
        ram_raddr = idx_r;
        ptr_nxt   = idx_r;
        state_nxt = S_TAKE;
      end

      // Remove: capture it, then close the gap if anything follows
      S_TAKE: begin
        removed_nxt = ram_rdata;
        if (CW'(ptr_inc) < count_r && CW'(ptr_r) + CW'(1) < count_r) begin
          state_nxt = S_MRD;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      // Remove: read the entry after the gap
      S_MRD: begin
        ram_raddr = ptr_inc;
        state_nxt = S_MWR;
      end

      // Remove: move it one slot forward
      S_MWR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = ram_rdata;
        ptr_nxt   = ptr_inc;
        if (CW'(ptr_r) + CW'(2) < count_r) begin
          state_nxt = S_MRD;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      // Hand the result over once the output slot is free
      S_DONE: begin
        if (slot_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result beat
  assign res.status       = status_r;
  assign res.removed_data = removed_r;
  assign res.entry_count  = 5'(count_r);

endmodule

// ----- src/positional_list_engine_core.sv -----
// Positional list engine: ordered byte list with insert and remove at any position.
// Insert moves each entry behind the slot back one place, then writes the new byte;
// remove reads the victim, then moves each entry after it forward; errors and unused
// codes go straight to the result. One request at a time: the next is taken the cycle
// after the result reaches the output register, which holds the sequencer while full.
// Reset empties the list at once; memory contents need no clearing.
module positional_list_engine_core #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ple_req_if.sink   in_req,
  ple_rsp_if.source out_rsp
);
  import ple_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          slot_free;
  logic          res_valid;
  result_t       res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          out_valid_r;
  result_t       out_res_r;

  ple_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_req.valid),
    .req_ready (in_req.ready),
    .req_action(in_req.action),
    .req_data  (in_req.item_data),
    .req_pos   (in_req.position),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ple_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_list_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Output slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_rsp.ready;

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_res_r.status;
  assign out_rsp.removed_data = out_res_r.removed_data;
  assign out_rsp.entry_count  = out_res_r.entry_count;

endmodule
